### rtl/bws_pkg.sv
// Shared types, constants and the luma function of the brightest window search.
package bws_pkg;

  localparam int MaxWindow  = 64;
  localparam int MaxWidth   = 2048;
  localparam int MaxHeight  = 2048;

  localparam int PixW       = 8;
  localparam int LumaW      = 18;
  localparam int ColSumW    = 24;
  localparam int WinSumW    = 30;
  localparam int CoordW     = 11;
  localparam int WinCfgW    = 7;
  localparam int DimCfgW    = 12;
  localparam int CfgIdxW    = 2;
  localparam int SlotW      = $clog2(MaxWindow);
  localparam int LineAddrW  = SlotW + CoordW;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [WinCfgW-1:0] WindowSizeRst  = WinCfgW'(8);
  localparam logic [DimCfgW-1:0] ImageWidthRst  = DimCfgW'(640);
  localparam logic [DimCfgW-1:0] ImageHeightRst = DimCfgW'(480);

  localparam logic [LumaW-1:0] LumaWeightR = LumaW'(299);
  localparam logic [LumaW-1:0] LumaWeightG = LumaW'(587);
  localparam logic [LumaW-1:0] LumaWeightB = LumaW'(114);

  typedef enum logic [CfgIdxW-1:0] {
    CfgWindowSize  = 2'd0,
    CfgImageWidth  = 2'd1,
    CfgImageHeight = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CoordW-1:0]  row;
    logic [CoordW-1:0]  col;
    logic [WinSumW-1:0] sum;
    logic               found;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

  // Luma scaled by 1000; the largest value fits in LumaW bits.
  function automatic logic [LumaW-1:0] luma_of(input logic [PixW-1:0] r,
                                               input logic [PixW-1:0] g,
                                               input logic [PixW-1:0] b);
    return LumaW'(r) * LumaWeightR + LumaW'(g) * LumaWeightG + LumaW'(b) * LumaWeightB;
  endfunction

endpackage

### rtl/bws_mod_unit.sv
// Restoring remainder unit, one quotient bit per cycle, for ring position recompute.
module bws_mod_unit import bws_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CoordW-1:0]   dividend_i,
  input  logic [WinCfgW-1:0]  divisor_i,
  output mod_status_t         status_o,
  output logic [WinCfgW-1:0]  rem_o
);

  localparam int StepCntW = $clog2(CoordW + 1);

  logic                busy_q, done_q;
  logic [StepCntW-1:0] step_q;
  logic [CoordW-1:0]   dvd_q;
  logic [WinCfgW-1:0]  dvs_q;
  logic [WinCfgW-1:0]  rem_q, rem_d;
  logic [WinCfgW:0]    trial;

  always_comb begin
    trial = {rem_q, dvd_q[CoordW-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = WinCfgW'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[WinCfgW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + StepCntW'(1);
      if (step_q == StepCntW'(CoordW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[CoordW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign status_o.busy = busy_q | done_q;
  assign status_o.done = done_q;
  assign rem_o         = rem_q;

endmodule

### rtl/brightest_window_search_core.sv
// A frame's result goes through the pipeline registers and the result queue to m_axis.
// Throughput: one pixel per cycle while s_axis_tready is high; the line store, column
// sums and recent sums are read one stage ahead of their update and forwarded when
// consecutive pixels collide. Reset: control clears at once, then a pass zeroes the
// column sums and recent sums with s_axis_tready low. A register write holds s_axis_tready
// low while the row and column ring positions are recomputed modulo the window size.
module brightest_window_search_core import bws_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [55:0]          m_axis_tdata,   // best_row[10:0], best_col[21:11],
                                               // best_sum[51:22], zero fill
  output logic                 m_axis_tuser,   // found
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [DimCfgW-1:0]   cfg_data_i
);

  typedef struct packed {
    logic [LumaW-1:0]     luma;
    logic [CoordW-1:0]    col;
    logic [LineAddrW-1:0] addr;
    logic [SlotW-1:0]     ring;
    logic                 eval;
    logic                 row0;
    logic                 rge;
    logic                 c0;
    logic                 cge;
    logic                 win_ok;
    logic                 first;
    logic                 last;
    logic [CoordW-1:0]    pos_row;
    logic [CoordW-1:0]    pos_col;
    logic                 lfwd;
    logic [LumaW-1:0]     lfwd_data;
    logic                 cfwd;
    logic [ColSumW-1:0]   cfwd_data;
  } s1_t;

  typedef struct packed {
    logic [ColSumW-1:0]   cs;
    logic [SlotW-1:0]     ring;
    logic                 eval;
    logic                 c0;
    logic                 cge;
    logic                 win_ok;
    logic                 first;
    logic                 last;
    logic [CoordW-1:0]    pos_row;
    logic [CoordW-1:0]    pos_col;
    logic                 rfwd;
    logic [ColSumW-1:0]   rfwd_data;
  } s2_t;

  typedef struct packed {
    logic [WinSumW-1:0]   ws;
    logic                 eval;
    logic                 win_ok;
    logic                 first;
    logic                 last;
    logic [CoordW-1:0]    pos_row;
    logic [CoordW-1:0]    pos_col;
  } s3_t;

  // Configuration
  logic [WinCfgW-1:0] win_size_q;
  logic [DimCfgW-1:0] img_w_q, img_h_q;
  logic [DimCfgW-1:0] w_eff, h_eff;
  logic               n_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= WindowSizeRst;
      img_w_q    <= ImageWidthRst;
      img_h_q    <= ImageHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgWindowSize:  win_size_q <= cfg_data_i[WinCfgW-1:0];
        CfgImageWidth:  img_w_q    <= cfg_data_i;
        CfgImageHeight: img_h_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (img_w_q == '0) begin
      w_eff = DimCfgW'(1);
    end else if (img_w_q > DimCfgW'(MaxWidth)) begin
      w_eff = DimCfgW'(MaxWidth);
    end else begin
      w_eff = img_w_q;
    end
    if (img_h_q == '0) begin
      h_eff = DimCfgW'(1);
    end else if (img_h_q > DimCfgW'(MaxHeight)) begin
      h_eff = DimCfgW'(MaxHeight);
    end else begin
      h_eff = img_h_q;
    end
  end

  assign n_valid = (win_size_q != '0) && (win_size_q <= WinCfgW'(MaxWindow));

  // Ring position recompute after a register write
  mod_status_t        row_mod_st, col_mod_st;
  logic [WinCfgW-1:0] row_mod_rem, col_mod_rem;
  logic [WinCfgW-1:0] mod_divisor;
  logic [CoordW-1:0]  row_q, col_q;
  logic [SlotW-1:0]   slot_q, ring_q;

  // take the incoming window size when it is the register being written
  assign mod_divisor = (cfg_we_i && (cfg_idx_e'(cfg_index_i) == CfgWindowSize))
                       ? cfg_data_i[WinCfgW-1:0] : win_size_q;

  bws_mod_unit u_row_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_we_i),
    .dividend_i (row_q),
    .divisor_i  (mod_divisor),
    .status_o   (row_mod_st),
    .rem_o      (row_mod_rem)
  );

  bws_mod_unit u_col_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_we_i),
    .dividend_i (col_q),
    .divisor_i  (mod_divisor),
    .status_o   (col_mod_st),
    .rem_o      (col_mod_rem)
  );

  // Clearing pass over the column sums and recent sums
  logic              clr_busy_q;
  logic [CoordW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + CoordW'(1);
      if (clr_cnt_q == CoordW'(MaxWidth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Input side
  logic [QueueCntW-1:0] pending_q;
  logic                 accept, pop;
  logic                 col_end, frame_end;
  logic [SlotW:0]       slot_inc, ring_inc;
  logic [SlotW-1:0]     slot_wrap, ring_wrap;
  logic [LineAddrW-1:0] rd_addr;

  assign s_axis_tready = !clr_busy_q && !row_mod_st.busy && !col_mod_st.busy && !cfg_we_i
                         && (pending_q < QueueCntW'(QueueDepth));
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign col_end   = ({1'b0, col_q} + DimCfgW'(1)) >= w_eff;
  assign frame_end = col_end && (({1'b0, row_q} + DimCfgW'(1)) >= h_eff);
  assign slot_inc  = {1'b0, slot_q} + (SlotW+1)'(1);
  assign ring_inc  = {1'b0, ring_q} + (SlotW+1)'(1);
  assign slot_wrap = (slot_inc == win_size_q) ? '0 : slot_inc[SlotW-1:0];
  assign ring_wrap = (ring_inc == win_size_q) ? '0 : ring_inc[SlotW-1:0];
  assign rd_addr   = {slot_q, col_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
      ring_q <= '0;
    end else if (row_mod_st.done) begin
      slot_q <= row_mod_rem[SlotW-1:0];
      ring_q <= col_mod_rem[SlotW-1:0];
    end else if (accept) begin
      if (col_end) begin
        col_q  <= '0;
        ring_q <= '0;
        if (frame_end) begin
          row_q  <= '0;
          slot_q <= '0;
        end else begin
          row_q  <= row_q + CoordW'(1);
          slot_q <= slot_wrap;
        end
      end else begin
        col_q  <= col_q + CoordW'(1);
        ring_q <= ring_wrap;
      end
    end
  end

  // Stores
  logic [LumaW-1:0]   luma_mem [MaxWindow*MaxWidth];
  logic [ColSumW-1:0] colsum_mem [MaxWidth];
  logic [ColSumW-1:0] recent_mem [MaxWindow];
  logic [LumaW-1:0]   luma_rd_q;
  logic [ColSumW-1:0] colsum_rd_q, recent_rd_q;

  logic               s1_valid_q, s2_valid_q, s3_valid_q;
  s1_t                s1_q, s1_d;
  s2_t                s2_q, s2_d;
  s3_t                s3_q, s3_d;
  logic [ColSumW-1:0] cs_d;
  logic               colsum_we, recent_we;
  logic [CoordW-1:0]  colsum_wa;
  logic [SlotW-1:0]   recent_wa;
  logic [ColSumW-1:0] colsum_wd, recent_wd;

  assign colsum_we = clr_busy_q || (s1_valid_q && s1_q.eval);
  assign colsum_wa = clr_busy_q ? clr_cnt_q : s1_q.col;
  assign colsum_wd = clr_busy_q ? '0 : cs_d;
  assign recent_we = clr_busy_q || (s2_valid_q && s2_q.eval);
  assign recent_wa = clr_busy_q ? clr_cnt_q[SlotW-1:0] : s2_q.ring;
  assign recent_wd = clr_busy_q ? '0 : s2_q.cs;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_q.eval) begin
      luma_mem[s1_q.addr] <= s1_q.luma;
    end
    luma_rd_q <= luma_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (colsum_we) begin
      colsum_mem[colsum_wa] <= colsum_wd;
    end
    colsum_rd_q <= colsum_mem[col_q];
  end

  always_ff @(posedge clk_i) begin
    if (recent_we) begin
      recent_mem[recent_wa] <= recent_wd;
    end
    recent_rd_q <= recent_mem[s1_q.ring];
  end

  // Stage 1 capture: luma and position flags
  always_comb begin
    s1_d           = '0;
    s1_d.luma      = luma_of(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]);
    s1_d.col       = col_q;
    s1_d.addr      = rd_addr;
    s1_d.ring      = ring_q;
    s1_d.eval      = n_valid;
    s1_d.row0      = (row_q == '0);
    s1_d.rge       = row_q >= CoordW'(win_size_q);
    s1_d.c0        = (col_q == '0);
    s1_d.cge       = col_q >= CoordW'(win_size_q);
    s1_d.win_ok    = (({1'b0, row_q} + DimCfgW'(1)) >= DimCfgW'(win_size_q))
                     && (({1'b0, col_q} + DimCfgW'(1)) >= DimCfgW'(win_size_q));
    s1_d.first     = (row_q == '0) && (col_q == '0);
    s1_d.last      = frame_end;
    s1_d.pos_row   = row_q + CoordW'(1) - CoordW'(win_size_q);
    s1_d.pos_col   = col_q + CoordW'(1) - CoordW'(win_size_q);
    // forward the word the stage 1 item writes this cycle
    s1_d.lfwd      = s1_valid_q && s1_q.eval && (s1_q.addr == rd_addr);
    s1_d.lfwd_data = s1_q.luma;
    s1_d.cfwd      = s1_valid_q && s1_q.eval && (s1_q.col == col_q);
    s1_d.cfwd_data = cs_d;
  end

  // Stage 1 work: column sum
  logic [LumaW-1:0]   old_luma;
  logic [ColSumW-1:0] colsum_old;

  always_comb begin
    old_luma   = s1_q.lfwd ? s1_q.lfwd_data : luma_rd_q;
    colsum_old = s1_q.cfwd ? s1_q.cfwd_data : colsum_rd_q;
    if (s1_q.row0) begin
      cs_d = ColSumW'(s1_q.luma);
    end else if (s1_q.rge) begin
      cs_d = colsum_old + ColSumW'(s1_q.luma) - ColSumW'(old_luma);
    end else begin
      cs_d = colsum_old + ColSumW'(s1_q.luma);
    end
  end

  always_comb begin
    s2_d           = '0;
    s2_d.cs        = cs_d;
    s2_d.ring      = s1_q.ring;
    s2_d.eval      = s1_q.eval;
    s2_d.c0        = s1_q.c0;
    s2_d.cge       = s1_q.cge;
    s2_d.win_ok    = s1_q.win_ok;
    s2_d.first     = s1_q.first;
    s2_d.last      = s1_q.last;
    s2_d.pos_row   = s1_q.pos_row;
    s2_d.pos_col   = s1_q.pos_col;
    s2_d.rfwd      = s2_valid_q && s2_q.eval && (s2_q.ring == s1_q.ring);
    s2_d.rfwd_data = s2_q.cs;
  end

  // Stage 2 work: window sum
  logic [WinSumW-1:0] ws_q, ws_d;
  logic [ColSumW-1:0] recent_old;

  always_comb begin
    recent_old = s2_q.rfwd ? s2_q.rfwd_data : recent_rd_q;
    if (s2_q.c0) begin
      ws_d = WinSumW'(s2_q.cs);
    end else if (s2_q.cge) begin
      ws_d = ws_q + WinSumW'(s2_q.cs) - WinSumW'(recent_old);
    end else begin
      ws_d = ws_q + WinSumW'(s2_q.cs);
    end
  end

  always_comb begin
    s3_d         = '0;
    s3_d.ws      = ws_d;
    s3_d.eval    = s2_q.eval;
    s3_d.win_ok  = s2_q.win_ok;
    s3_d.first   = s2_q.first;
    s3_d.last    = s2_q.last;
    s3_d.pos_row = s2_q.pos_row;
    s3_d.pos_col = s2_q.pos_col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      ws_q       <= '0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (s2_valid_q && s2_q.eval) begin
        ws_q <= ws_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    s3_q <= s3_d;
  end

  // Stage 3: best window tracking
  logic [WinSumW-1:0] best_q, best_base, best_d;
  logic [CoordW-1:0]  best_row_q, best_col_q, row_base, col_base, best_row_d, best_col_d;
  logic               better;
  result_t            res;

  always_comb begin
    best_base = s3_q.first ? '0 : best_q;
    row_base  = s3_q.first ? '0 : best_row_q;
    col_base  = s3_q.first ? '0 : best_col_q;
    better    = s3_q.eval && s3_q.win_ok && (s3_q.ws > best_base);
    best_d     = better ? s3_q.ws : best_base;
    best_row_d = better ? s3_q.pos_row : row_base;
    best_col_d = better ? s3_q.pos_col : col_base;
    res.row   = best_row_d;
    res.col   = best_col_d;
    res.sum   = best_d;
    res.found = (best_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q     <= '0;
      best_row_q <= '0;
      best_col_q <= '0;
    end else if (s3_valid_q) begin
      best_q     <= best_d;
      best_row_q <= best_row_d;
      best_col_q <= best_col_d;
    end
  end

  // Result queue
  result_t              queue_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] q_cnt_q;
  logic                 push;

  assign push = s3_valid_q && s3_q.last;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      q_cnt_q   <= '0;
      pending_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      q_cnt_q   <= q_cnt_q + QueueCntW'(push) - QueueCntW'(pop);
      pending_q <= pending_q + QueueCntW'(accept && frame_end) - QueueCntW'(pop);
    end
  end

  assign m_axis_tvalid = (q_cnt_q != '0);
  assign m_axis_tdata  = {4'b0, queue_q[rd_ptr_q].sum, queue_q[rd_ptr_q].col,
                          queue_q[rd_ptr_q].row};
  assign m_axis_tuser  = queue_q[rd_ptr_q].found;

  // Checks
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= QueueCntW'(QueueDepth))
    else $error("results in flight exceed queue depth");

  a_queue_within_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= pending_q)
    else $error("queued results exceed pending count");

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready)
    else $error("pixel taken during column sum clear");

  a_accept_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted pixel missing from stage 1");

  a_ring_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_valid && s_axis_tready) |-> ({1'b0, slot_q} < win_size_q && {1'b0, ring_q} < win_size_q))
    else $error("ring position outside window size");

endmodule

### verif/testbench.sv
// Self-checking testbench of the brightest window search core: directed frames, then random frames.
module testbench;
  import bws_pkg::*;

  localparam int NumDirected = 10;
  localparam int SmallItems  = 1850;
  localparam int CycleLimit  = 500000;

  typedef enum logic [2:0] {
    PixWhite, PixBlack, PixRed, PixGreen, PixBlue, PixRandom, PixSparse
  } pix_mode_e;

  typedef struct packed {
    logic               wr_win;
    logic [WinCfgW-1:0] win;
    logic [DimCfgW-1:0] width;
    logic [DimCfgW-1:0] height;
    pix_mode_e          mode;
    logic               typed;
    result_t            res;
  } frame_case_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [55:0]        m_axis_tdata;
  logic               m_axis_tuser;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CfgWindowSize;
  logic [DimCfgW-1:0] cfg_data_i = '0;

  // Search state mirrored from the block
  bit [WinCfgW-1:0] win_size;
  bit [DimCfgW-1:0] img_width;
  bit [DimCfgW-1:0] img_height;
  bit [LumaW-1:0]   luma_lines [MaxWindow*MaxWidth];
  bit [ColSumW-1:0] column_totals [MaxWidth];
  bit [ColSumW-1:0] recent_totals [MaxWindow];
  bit [WinSumW-1:0] window_total;
  bit [WinSumW-1:0] best_total;
  bit [CoordW-1:0]  best_row;
  bit [CoordW-1:0]  best_col;
  bit [CoordW-1:0]  row_pos;
  bit [CoordW-1:0]  col_pos;

  result_t     awaited_windows [$];
  frame_case_t directed_frames [NumDirected];
  result_t     typed_res;
  bit          use_typed;
  bit          calm;
  int          error_count;
  int          cycle_count;
  int          small_count;

  brightest_window_search_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned eff_dim(input bit [DimCfgW-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Advance the search by one pixel; return 1 with the frame's best window on its last pixel.
  function automatic bit scan_pixel(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, output result_t res);
    int unsigned w, h, n, luma, idx;
    bit [ColSumW-1:0] cs;
    w = eff_dim(img_width, MaxWidth);
    h = eff_dim(img_height, MaxHeight);
    n = win_size;
    luma = r * LumaWeightR + g * LumaWeightG + b * LumaWeightB;
    res = '0;
    if (row_pos == 0 && col_pos == 0) begin
      best_total = '0;
      best_row = '0;
      best_col = '0;
    end
    if (n >= 1 && n <= MaxWindow) begin
      idx = (row_pos % n) * MaxWidth + col_pos;
      if (row_pos == 0) cs = luma;
      else if (row_pos >= n) cs = column_totals[col_pos] + luma - luma_lines[idx];
      else cs = column_totals[col_pos] + luma;
      column_totals[col_pos] = cs;
      luma_lines[idx] = luma;
      if (col_pos == 0) window_total = cs;
      else if (col_pos >= n) window_total = window_total + cs - recent_totals[col_pos % n];
      else window_total = window_total + cs;
      recent_totals[col_pos % n] = cs;
      if (row_pos + 1 >= n && col_pos + 1 >= n && window_total > best_total) begin
        best_total = window_total;
        best_row = row_pos + 1 - n;
        best_col = col_pos + 1 - n;
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = '0;
      if (row_pos + 1 >= h) begin
        row_pos = '0;
        res.row = best_row;
        res.col = best_col;
        res.sum = best_total;
        res.found = (best_total != 0);
        return 1'b1;
      end
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return 1'b0;
  endfunction

  function automatic logic [23:0] pick_pixel(input pix_mode_e mode);
    logic [23:0] px;
    px = 24'($urandom());
    case (mode)
      PixWhite:  return 24'hFFFFFF;
      PixBlack:  return 24'h000000;
      PixRed:    return 24'h0000FF;
      PixGreen:  return 24'h00FF00;
      PixBlue:   return 24'hFF0000;
      PixSparse: return ($urandom_range(0, 7) == 0) ? px : 24'h000000;
      default:   return px;
    endcase
  endfunction

  // Leaves tvalid high at a falling edge; the caller drives it again before time moves.
  task automatic send_pixel(input logic [23:0] px);
    result_t res;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = px;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    if (scan_pixel(px[7:0], px[15:8], px[23:16], res))
      awaited_windows.push_back(use_typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  task automatic run_frame(input pix_mode_e mode);
    int unsigned total;
    total = eff_dim(img_width, MaxWidth) * eff_dim(img_height, MaxHeight);
    repeat (total) send_pixel(pick_pixel(mode));
  endtask

  // Hold the stream until every awaited result is out, then let the pipeline drain.
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (awaited_windows.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DimCfgW-1:0] data);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgWindowSize:  win_size = data[WinCfgW-1:0];
      CfgImageWidth:  img_width = data;
      CfgImageHeight: img_height = data;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_windows.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual row %0d col %0d sum %0d",
                 $time, m_axis_tdata[10:0], m_axis_tdata[21:11], m_axis_tdata[51:22]);
        error_count++;
      end else begin
        want = awaited_windows.pop_front();
        check_field("best_row", want.row, m_axis_tdata[10:0]);
        check_field("best_col", want.col, m_axis_tdata[21:11]);
        check_field("best_sum", want.sum, m_axis_tdata[51:22]);
        check_field("found", want.found, m_axis_tuser);
      end
    end
  end

  // Result side: random stall bursts, dropped once the run turns calm.
  always begin
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      m_axis_tready = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
      m_axis_tready = 1'b1;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 60)) @(negedge clk_i);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d results awaited", $time, awaited_windows.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n, w, h, kind, frames, first;
    pix_mode_e mode;
    win_size = WindowSizeRst;
    img_width = ImageWidthRst;
    img_height = ImageHeightRst;
    // white luma is 255000; red, green and blue alone give 76245, 149685 and 29070
    directed_frames[0] = '{1'b0, 7'd0, 12'd8, 12'd1, PixWhite, 1'b1, '{11'd0, 11'd0, 30'd0, 1'b0}};
    directed_frames[1] = '{1'b1, 7'd1, 12'd1, 12'd1, PixWhite, 1'b1,
                           '{11'd0, 11'd0, 30'd255000, 1'b1}};
    directed_frames[2] = '{1'b1, 7'd1, 12'd1, 12'd1, PixBlack, 1'b1,
                           '{11'd0, 11'd0, 30'd0, 1'b0}};
    directed_frames[3] = '{1'b1, 7'd1, 12'd0, 12'd0, PixRed, 1'b1,
                           '{11'd0, 11'd0, 30'd76245, 1'b1}};
    directed_frames[4] = '{1'b1, 7'd1, 12'd1, 12'd1, PixGreen, 1'b1,
                           '{11'd0, 11'd0, 30'd149685, 1'b1}};
    directed_frames[5] = '{1'b1, 7'd1, 12'd1, 12'd1, PixBlue, 1'b1,
                           '{11'd0, 11'd0, 30'd29070, 1'b1}};
    directed_frames[6] = '{1'b1, 7'd0, 12'd2, 12'd2, PixWhite, 1'b1,
                           '{11'd0, 11'd0, 30'd0, 1'b0}};
    directed_frames[7] = '{1'b1, 7'd127, 12'd1, 12'd1, PixWhite, 1'b1,
                           '{11'd0, 11'd0, 30'd0, 1'b0}};
    directed_frames[8] = '{1'b1, 7'd2, 12'd3, 12'd2, PixRandom, 1'b0,
                           '{11'd0, 11'd0, 30'd0, 1'b0}};
    // a tie across the row: the first window wins
    directed_frames[9] = '{1'b1, 7'd1, 12'd3, 12'd1, PixWhite, 1'b1,
                           '{11'd0, 11'd0, 30'd255000, 1'b1}};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      settle();
      if (directed_frames[i].wr_win)
        write_reg(CfgWindowSize, DimCfgW'(directed_frames[i].win));
      write_reg(CfgImageWidth, directed_frames[i].width);
      write_reg(CfgImageHeight, directed_frames[i].height);
      use_typed = directed_frames[i].typed;
      typed_res = directed_frames[i].res;
      run_frame(directed_frames[i].mode);
    end
    use_typed = 1'b0;

    while (small_count < SmallItems) begin
      settle();
      kind = $urandom_range(0, 19);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      n = $urandom_range(1, ((w < h) ? w : h) + 1);
      case (kind)
        0: n = 0;
        1: n = $urandom_range(MaxWindow + 1, 127);
        2: begin
          n = MaxWindow;
          w = $urandom_range(60, 70);
          h = $urandom_range(1, 2);
        end
        3: w = 0;
        4: h = 0;
        5: begin
          w = $urandom_range(13, 40);
          h = $urandom_range(1, 3);
          n = $urandom_range(1, h);
        end
        6: begin
          w = $urandom_range(1, 3);
          h = $urandom_range(11, 40);
          n = $urandom_range(1, w);
        end
        default: ;
      endcase
      // write all three registers, starting at a random one
      first = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        case ((first + k) % 3)
          0: write_reg(CfgWindowSize, {5'($urandom_range(0, 31)), 7'(n)});
          1: write_reg(CfgImageWidth, DimCfgW'(w));
          default: write_reg(CfgImageHeight, DimCfgW'(h));
        endcase
      end
      frames = $urandom_range(1, 4);
      repeat (frames) begin
        case ($urandom_range(0, 9))
          0: mode = PixBlack;
          1: mode = PixWhite;
          2, 3: mode = PixSparse;
          default: mode = PixRandom;
        endcase
        run_frame(mode);
        small_count += eff_dim(img_width, MaxWidth) * eff_dim(img_height, MaxHeight);
      end
      if (small_count >= SmallItems * 5 / 6) calm = 1'b1;
    end

    s_axis_tvalid = 1'b0;
    while (awaited_windows.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
